// ===== sv/sdcm_pkg.sv =====
// sdcm_pkg: shared types and constants of the complex sparse-dense accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdcm_pkg;

  localparam int unsigned FracBits = 27;

  typedef enum logic [1:0] {
    ACT_LOAD_DENSE = 2'd0,
    ACT_LOAD_OUT   = 2'd1,
    ACT_NONZERO    = 2'd2,
    ACT_READ       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_VLEN  = 2'd0,
    REG_CONJ  = 2'd1,
    REG_SCRE  = 2'd2,
    REG_SCIM  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SCALE_SUM,
    ST_RUN,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         dense_vector;
    logic [5:0]         out_vector;
    logic [5:0]         element;
    logic signed [47:0] value_real;
    logic signed [47:0] value_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] result_real;
    logic signed [47:0] result_imag;
    logic               overflow;
  } out_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -50'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Round a Q.54 product to Q.27: add half, arithmetic shift.
  function automatic logic signed [36:0] round27(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = {p[63], p} + 65'sd67108864;
    return t[63:27];
  endfunction

endpackage
`default_nettype wire

// ===== sv/sdcm_cmac.sv =====
// sdcm_cmac: pipelined complex multiply, rounding and saturating accumulate.
// Uses sdcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdcm_cmac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [31:0] sr_i,
  input  wire logic signed [31:0] si_i,
  input  wire logic signed [31:0] dr_i,
  input  wire logic signed [31:0] di_i,
  input  wire logic signed [47:0] acc_re_i,
  input  wire logic signed [47:0] acc_im_i,
  output logic signed [47:0]      sum_re_o,
  output logic signed [47:0]      sum_im_o,
  output logic                    ovf_o
);
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [38:0] pr, pi;
  logic signed [49:0] s_re, s_im;

  // Products registered; the accumulate works combinationally on the registered products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= sr_i * dr_i;
      p_ii_q <= si_i * di_i;
      p_ri_q <= sr_i * di_i;
      p_ir_q <= si_i * dr_i;
    end
  end

  always_comb begin
    pr = 39'(sdcm_pkg::round27(p_rr_q)) - 39'(sdcm_pkg::round27(p_ii_q));
    pi = 39'(sdcm_pkg::round27(p_ri_q)) + 39'(sdcm_pkg::round27(p_ir_q));
    s_re = 50'(acc_re_i) + 50'(pr);
    s_im = 50'(acc_im_i) + 50'(pi);
    ovf_o = 1'b0;
    if (s_re > 50'sh7FFFFFFFFFFF) begin sum_re_o = 48'sh7FFFFFFFFFFF; ovf_o = 1'b1; end
    else if (s_re < -50'sh800000000000) begin
      sum_re_o = 48'sh800000000000; ovf_o = 1'b1;
    end else sum_re_o = s_re[47:0];
    if (s_im > 50'sh7FFFFFFFFFFF) begin sum_im_o = 48'sh7FFFFFFFFFFF; ovf_o = 1'b1; end
    else if (s_im < -50'sh800000000000) begin
      sum_im_o = 48'sh800000000000; ovf_o = 1'b1;
    end else sum_im_o = s_im[47:0];
  end

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
`default_nettype wire

// ===== sv/sparse_dense_complex_matmul_acc_top.sv =====
// Top level of the complex sparse-times-dense accumulator.
// Uses sdcm_pkg and sdcm_cmac.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  | signals                                | beat
//  ---------+----------------------------------------+---------------------------
//  input    | in_valid_i, in_ready_o, in_item_i      | one load, nonzero or read
//  output   | out_valid_o, out_ready_i, out_item_o   | one element and the flag
//  config   | cfg_we_i, cfg_index_i, cfg_data_i      | one register write
//
//  Loads are written while idle; a read passes through ST_READ into the output
//  register, then the output handshake. A nonzero runs the scale multiply,
//  then one element per cycle through the read-modify-write loop on the
//  output memory (read, multiply, add and write back).
//  Non-read beats are accepted while a result waits in the output register.
//  Reset clears control and the overflow flag, and sets the config registers
//  to defaults; memories keep their contents and are undefined until written.
module sparse_dense_complex_matmul_acc_top #(
  parameter int unsigned MAX_VECTOR_LEN    = 64,
  parameter int unsigned NUM_DENSE_VECTORS = 64,
  parameter int unsigned NUM_OUT_VECTORS   = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sdcm_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sdcm_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  localparam int unsigned EW = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1;
  localparam int unsigned DW = (NUM_DENSE_VECTORS > 1) ? $clog2(NUM_DENSE_VECTORS) : 1;
  localparam int unsigned OW = (NUM_OUT_VECTORS > 1) ? $clog2(NUM_OUT_VECTORS) : 1;
  localparam int unsigned DA = DW + EW;
  localparam int unsigned OA = OW + EW;
  localparam int unsigned LW = $clog2(MAX_VECTOR_LEN + 1);

  // Configuration registers.
  logic [6:0]         vlen_q;
  logic               conj_q;
  logic signed [31:0] scre_q, scim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= 7'd64;
      conj_q <= 1'b0;
      scre_q <= 32'sd134217728;
      scim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdcm_pkg::REG_VLEN: vlen_q <= cfg_data_i[6:0];
        sdcm_pkg::REG_CONJ: conj_q <= cfg_data_i[0];
        sdcm_pkg::REG_SCRE: scre_q <= cfg_data_i;
        sdcm_pkg::REG_SCIM: scim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memories.
  logic [63:0]        dense_mem [NUM_DENSE_VECTORS * MAX_VECTOR_LEN];
  logic signed [47:0] ore_mem   [NUM_OUT_VECTORS * MAX_VECTOR_LEN];
  logic signed [47:0] oim_mem   [NUM_OUT_VECTORS * MAX_VECTOR_LEN];

  sdcm_pkg::state_e   state_q, state_d;
  logic [DW-1:0]      dv_q;
  logic [OW-1:0]      ov_q;
  logic signed [31:0] ar_q, ai_q;
  logic signed [31:0] sr_q, si_q;
  logic [LW-1:0]      rd_cnt_q, len_q;
  logic               rd_go_q, mul_go_q;
  logic [EW-1:0]      mul_el_q;
  logic               ovf_q;
  logic               out_valid_q;
  sdcm_pkg::out_item_t out_q;
  logic               rd_ok_q;

  // Scale multiply products.
  logic signed [63:0] sp_rr_q, sp_ii_q, sp_ri_q, sp_ir_q;
  logic signed [49:0] ssr, ssi;
  assign ssr = 50'(sdcm_pkg::round27(sp_rr_q)) - 50'(sdcm_pkg::round27(sp_ii_q));
  assign ssi = 50'(sdcm_pkg::round27(sp_ri_q)) + 50'(sdcm_pkg::round27(sp_ir_q));

  logic acc_in;
  logic dv_ok, ov_ok, el_ok;
  assign acc_in = in_valid_i && in_ready_o;
  assign dv_ok  = 32'(in_item_i.dense_vector) < NUM_DENSE_VECTORS;
  assign ov_ok  = 32'(in_item_i.out_vector) < NUM_OUT_VECTORS;
  assign el_ok  = 32'(in_item_i.element) < MAX_VECTOR_LEN;

  logic [DA-1:0] ld_daddr;
  logic [OA-1:0] ld_oaddr;
  assign ld_daddr = {DW'(in_item_i.dense_vector), EW'(in_item_i.element)};
  assign ld_oaddr = {OW'(in_item_i.out_vector), EW'(in_item_i.element)};

  logic signed [49:0] vim_c;
  assign vim_c = conj_q ? -50'(sdcm_pkg::sat32(50'(in_item_i.value_imag)))
                        : 50'(in_item_i.value_imag);

  // Loop read stage: read dense and output entries of element rd_cnt.
  logic [63:0]        d_rd_q;
  logic signed [47:0] ore_rd_q, oim_rd_q;
  logic [EW-1:0]      rd_el;
  assign rd_el = rd_cnt_q[EW-1:0];

  logic signed [47:0] sum_re, sum_im;
  logic               cmac_ovf;
  logic signed [47:0] acc_re_in, acc_im_in;
  logic signed [47:0] ore_rd_q_d1, oim_rd_q_d1;

  // Delay the output store read data through the _d1 registers to line up with
  // the registered products. Element indexes differ within one pass and passes
  // never overlap, so no read meets a pending write to its entry.
  assign acc_re_in = ore_rd_q_d1;
  assign acc_im_in = oim_rd_q_d1;

  sdcm_cmac u_cmac (
    .clk_i, .rst_ni,
    .en_i     (rd_go_q),
    .sr_i     (sr_q),
    .si_i     (si_q),
    .dr_i     (d_rd_q[31:0]),
    .di_i     (d_rd_q[63:32]),
    .acc_re_i (acc_re_in),
    .acc_im_i (acc_im_in),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im),
    .ovf_o    (cmac_ovf)
  );

  always_ff @(posedge clk_i) begin
    if (acc_in && in_item_i.action == sdcm_pkg::ACT_LOAD_DENSE && dv_ok && el_ok)
      dense_mem[ld_daddr] <= {sdcm_pkg::sat32(50'(in_item_i.value_imag)),
                              sdcm_pkg::sat32(50'(in_item_i.value_real))};
    d_rd_q <= dense_mem[{dv_q, rd_el}];
  end

  logic [OA-1:0] o_raddr, o_waddr;
  logic          o_we;
  logic signed [47:0] o_wre, o_wim;
  always_comb begin
    o_raddr = (state_q == sdcm_pkg::ST_RUN) ? {ov_q, rd_el} : ld_oaddr;
    if (mul_go_q) begin
      o_we = 1'b1; o_waddr = {ov_q, mul_el_q}; o_wre = sum_re; o_wim = sum_im;
    end else begin
      o_we = acc_in && in_item_i.action == sdcm_pkg::ACT_LOAD_OUT && ov_ok && el_ok;
      o_waddr = ld_oaddr;
      o_wre = in_item_i.value_real;
      o_wim = in_item_i.value_imag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_we) begin
      ore_mem[o_waddr] <= o_wre;
      oim_mem[o_waddr] <= o_wim;
    end
    ore_rd_q <= ore_mem[o_raddr];
    oim_rd_q <= oim_mem[o_raddr];
    ore_rd_q_d1 <= ore_rd_q;
    oim_rd_q_d1 <= oim_rd_q;
    if (state_q == sdcm_pkg::ST_IDLE && acc_in) begin
      dv_q <= DW'(in_item_i.dense_vector);
      ov_q <= OW'(in_item_i.out_vector);
      ar_q <= sdcm_pkg::sat32(50'(in_item_i.value_real));
      ai_q <= sdcm_pkg::sat32(vim_c);
    end
    if (state_q == sdcm_pkg::ST_SCALE) begin
      sp_rr_q <= scre_q * ar_q;
      sp_ii_q <= scim_q * ai_q;
      sp_ri_q <= scre_q * ai_q;
      sp_ir_q <= scim_q * ar_q;
    end
    if (state_q == sdcm_pkg::ST_SCALE_SUM) begin
      sr_q <= sdcm_pkg::sat32(ssr);
      si_q <= sdcm_pkg::sat32(ssi);
    end
  end

  // Control pipeline: read (rd_go) -> multiply (mul_go), whose sum is added and
  // written back in the same cycle.
  // Read data of the output store is delayed through a further register to line
  // up with the registered products.
  logic [EW-1:0] rd_el_d1;
  logic          scale_ovf;
  assign scale_ovf = (ssr > 50'sd2147483647) || (ssr < -50'sd2147483648) ||
                     (ssi > 50'sd2147483647) || (ssi < -50'sd2147483648);

  logic [6:0] vlen_cl;
  assign vlen_cl = (32'(vlen_q) > MAX_VECTOR_LEN) ? 7'(MAX_VECTOR_LEN) : vlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdcm_pkg::ST_IDLE;
      rd_cnt_q    <= '0;
      len_q       <= '0;
      rd_go_q     <= 1'b0;
      mul_go_q    <= 1'b0;
      rd_el_d1    <= '0;
      mul_el_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_go_q  <= (state_q == sdcm_pkg::ST_RUN) && (rd_cnt_q < len_q);
      rd_el_d1 <= rd_el;
      mul_go_q <= rd_go_q;
      mul_el_q <= rd_el_d1;
      if (state_q == sdcm_pkg::ST_IDLE) begin
        rd_cnt_q <= '0;
        len_q    <= LW'(vlen_cl);
        rd_ok_q  <= ov_ok && el_ok;
      end else if (state_q == sdcm_pkg::ST_RUN && rd_cnt_q < len_q) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (state_q == sdcm_pkg::ST_SCALE_SUM && scale_ovf) ovf_q <= 1'b1;
      if (mul_go_q && cmac_ovf) ovf_q <= 1'b1;
      if (state_q == sdcm_pkg::ST_READ) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sdcm_pkg::ST_READ) begin
      out_q.result_real <= rd_ok_q ? ore_rd_q : '0;
      out_q.result_imag <= rd_ok_q ? oim_rd_q : '0;
      out_q.overflow    <= ovf_q;
    end
  end

  // Next state; ready only in idle, and a read waits for the output register.
  // A nonzero with valid vector indexes runs the scale multiply, which can
  // raise the flag even when the vector length is zero.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      sdcm_pkg::ST_IDLE: begin
        in_ready_o = !(in_item_i.action == sdcm_pkg::ACT_READ &&
                       out_valid_q && !out_ready_i);
        if (acc_in) begin
          if (in_item_i.action == sdcm_pkg::ACT_READ) state_d = sdcm_pkg::ST_READ;
          else if (in_item_i.action == sdcm_pkg::ACT_NONZERO && dv_ok && ov_ok)
            state_d = sdcm_pkg::ST_SCALE;
        end
      end
      sdcm_pkg::ST_SCALE:     state_d = sdcm_pkg::ST_SCALE_SUM;
      sdcm_pkg::ST_SCALE_SUM: state_d = sdcm_pkg::ST_RUN;
      sdcm_pkg::ST_RUN:
        if (rd_cnt_q >= len_q && !rd_go_q && !mul_go_q)
          state_d = sdcm_pkg::ST_IDLE;
      sdcm_pkg::ST_READ:      state_d = sdcm_pkg::ST_IDLE;
      default:                state_d = sdcm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule
`default_nettype wire

// ===== sv/sdcm_checker.sv =====
// sdcm_checker: port-level checks of the accumulator, bound to the top level.
// Uses sdcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdcm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire sdcm_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire sdcm_pkg::out_item_t out_item_o
);
  // Remember that some result beat already showed the overflow flag.
  logic seen_ovf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seen_ovf_q <= 1'b0;
    else if (out_valid_o && out_item_o.overflow) seen_ovf_q <= 1'b1;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output beat dropped or changed while stalled");
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ovf_q |-> out_item_o.overflow)
    else $error("overflow flag cleared");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.action == sdcm_pkg::ACT_READ |=> ##1 out_valid_o)
    else $error("read gave no result");
  a_busy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.action == sdcm_pkg::ACT_READ |=> !in_ready_o)
    else $error("accepted a beat during a read");
endmodule

bind sparse_dense_complex_matmul_acc_top sdcm_checker u_sdcm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
  .out_valid_o, .out_ready_i, .out_item_o
);
`default_nettype wire
